// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms used by the translator datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising edge, disabled while reset is low.
`define ASSERT_CLK_RST(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on the rising edge, active also during reset.
`define ASSERT_CLK(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/tlbpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Field widths and controller/datapath signal groups of the translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

	localparam int ADDR_W     = 16;
	localparam int OFFSET_W   = 8;
	localparam int PAGE_NUM_W = 8;
	localparam int PA_W       = 15;
	localparam int CNT_W      = 32;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit_hit;
		logic commit_miss;
	} tlbpt_cmd_t;

	typedef struct packed {
		logic tlb_hit;
		logic out_free;
	} tlbpt_status_t;

endpackage

// ----- sv/tlbpt_channels.sv -----
// ----------------------------------------------------------------------------
// tlbpt channels
// Valid/ready channels for address requests and translation responses.
// ----------------------------------------------------------------------------
interface tlbpt_req_if;
	logic                          valid;
	logic                          ready;
	logic [tlbpt_pkg::ADDR_W-1:0]  logical_address;

	modport source (output valid, output logical_address, input ready);
	modport sink (input valid, input logical_address, output ready);
endinterface

interface tlbpt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [tlbpt_pkg::PA_W-1:0]       physical_address;
	logic                            tlb_hit;
	logic                            page_fault;
	logic                            evicted_valid;
	logic [tlbpt_pkg::PAGE_NUM_W-1:0] evicted_page;
	logic [tlbpt_pkg::CNT_W-1:0]      hit_total;
	logic [tlbpt_pkg::CNT_W-1:0]      fault_total;

	modport source (
		output valid, output physical_address, output tlb_hit, output page_fault,
		output evicted_valid, output evicted_page, output hit_total,
		output fault_total, input ready
	);
	modport sink (
		input valid, input physical_address, input tlb_hit, input page_fault,
		input evicted_valid, input evicted_page, input hit_total,
		input fault_total, output ready
	);
endinterface

// ----- sv/tlbpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Sequencer: accept, TLB lookup, page table access, commit of one item.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  tlbpt_pkg::tlbpt_status_t status,
	output tlbpt_pkg::tlbpt_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MISS
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.lookup = 1'b1;
				if (!status.tlb_hit) begin
					state_nx = ST_MISS;
				end else if (status.out_free) begin
					cmd.commit_hit = 1'b1;
					state_nx       = ST_IDLE;
				end
			end
			ST_MISS: begin
				if (status.out_free) begin
					cmd.commit_miss = 1'b1;
					state_nx        = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/tlbpt_datapath.sv -----
// ----------------------------------------------------------------------------
// tlbpt_datapath
// TLB, page table, frame owner table, FIFO victim pointer, counters and
// the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlbpt_datapath #(
	parameter int TLB_ENTRIES = 16,
	parameter int PAGE_COUNT  = 256,
	parameter int FRAME_TOTAL = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [tlbpt_pkg::ADDR_W-1:0]     logical_address,
	input  tlbpt_pkg::tlbpt_cmd_t            cmd,
	output tlbpt_pkg::tlbpt_status_t         status,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [tlbpt_pkg::PA_W-1:0]       physical_address,
	output logic                             tlb_hit,
	output logic                             page_fault,
	output logic                             evicted_valid,
	output logic [tlbpt_pkg::PAGE_NUM_W-1:0] evicted_page,
	output logic [tlbpt_pkg::CNT_W-1:0]      hit_total,
	output logic [tlbpt_pkg::CNT_W-1:0]      fault_total
);

	localparam int TW     = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int PW     = $clog2(PAGE_COUNT);
	localparam int FW     = (FRAME_TOTAL > 1) ? $clog2(FRAME_TOTAL) : 1;
	localparam int OW     = tlbpt_pkg::OFFSET_W;
	localparam int NW     = tlbpt_pkg::PAGE_NUM_W;
	localparam int CW     = tlbpt_pkg::CNT_W;
	localparam int PAFW   = tlbpt_pkg::PA_W - tlbpt_pkg::OFFSET_W;
	localparam int NPAGES = 1 << NW;

	typedef logic [NPAGES-1:0][PW-1:0] page_lut_t;

	function automatic page_lut_t build_page_lut();
		page_lut_t lut;
		int        i;
		for (i = 0; i < NPAGES; i++) begin
			lut[i] = PW'(i % PAGE_COUNT);
		end
		return lut;
	endfunction

	localparam page_lut_t PAGE_LUT = build_page_lut();

	// item registers
	logic [PW-1:0] page_q;
	logic [OW-1:0] offset_q;

	// TLB
	logic [PW-1:0]          tag_q   [TLB_ENTRIES];
	logic [FW-1:0]          tframe_q[TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tvalid_q;
	logic [TLB_ENTRIES-1:0] tvalid_nx;
	logic [TW-1:0]          fill_q;
	logic [TLB_ENTRIES-1:0] match;
	logic [FW-1:0]          tlb_frame;

	// page table and frame owners
	logic [FW-1:0]          map_mem  [PAGE_COUNT];
	logic [PW-1:0]          owner_mem[FRAME_TOTAL];
	logic [FW-1:0]          map_rd_q;
	logic [PW-1:0]          owner_rd_q;
	logic [PAGE_COUNT-1:0]  resident_q;
	logic [PAGE_COUNT-1:0]  resident_nx;
	logic [FRAME_TOTAL-1:0] owner_valid_q;
	logic [FW-1:0]          victim_q;

	logic [CW-1:0] hit_cnt_q;
	logic [CW-1:0] fault_cnt_q;
	logic [CW-1:0] hit_cnt_nx;
	logic [CW-1:0] fault_cnt_nx;

	logic          fault_now;
	logic          evict_now;
	logic          fault_commit;
	logic [FW-1:0] miss_frame;
	logic [FW-1:0] out_frame;
	logic [NW-1:0] frame_ext;

	always_comb begin
		tlb_frame = '0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			match[i] = tvalid_q[i] && (tag_q[i] == page_q);
			tlb_frame = tlb_frame | (match[i] ? tframe_q[i] : '0);
		end
	end

	assign fault_now    = !resident_q[page_q];
	assign evict_now    = fault_now && owner_valid_q[victim_q];
	assign fault_commit = cmd.commit_miss && fault_now;
	assign miss_frame   = fault_now ? victim_q : map_rd_q;
	assign out_frame    = cmd.commit_hit ? tlb_frame : miss_frame;
	assign frame_ext    = NW'(out_frame);
	assign hit_cnt_nx   = cmd.commit_hit ? hit_cnt_q + CW'(1) : hit_cnt_q;
	assign fault_cnt_nx = fault_commit ? fault_cnt_q + CW'(1) : fault_cnt_q;

	assign status.tlb_hit  = |match;
	assign status.out_free = !out_valid || out_ready;

	always_comb begin
		tvalid_nx   = tvalid_q;
		resident_nx = resident_q;
		if (cmd.commit_miss) begin
			if (evict_now) begin
				resident_nx[owner_rd_q] = 1'b0;
				for (int i = 0; i < TLB_ENTRIES; i++) begin
					if (tvalid_q[i] && (tag_q[i] == owner_rd_q)) begin
						tvalid_nx[i] = 1'b0;
					end
				end
			end
			if (fault_now) begin
				resident_nx[page_q] = 1'b1;
			end
			// fill after the drop so the new entry wins
			tvalid_nx[fill_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q      <= '0;
			fill_q        <= '0;
			resident_q    <= '0;
			owner_valid_q <= '0;
			victim_q      <= '0;
			hit_cnt_q     <= '0;
			fault_cnt_q   <= '0;
			out_valid     <= 1'b0;
		end else begin
			hit_cnt_q   <= hit_cnt_nx;
			fault_cnt_q <= fault_cnt_nx;
			tvalid_q    <= tvalid_nx;
			resident_q  <= resident_nx;
			if (fault_commit) begin
				owner_valid_q[victim_q] <= 1'b1;
				victim_q <= (victim_q == FW'(FRAME_TOTAL - 1)) ? '0 : victim_q + FW'(1);
			end
			if (cmd.commit_miss) begin
				fill_q <= (fill_q == TW'(TLB_ENTRIES - 1)) ? '0 : fill_q + TW'(1);
			end
			if (cmd.commit_hit || cmd.commit_miss) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			page_q   <= PAGE_LUT[logical_address[OW +: NW]];
			offset_q <= logical_address[OW-1:0];
		end
		if (cmd.lookup) begin
			map_rd_q   <= map_mem[page_q];
			owner_rd_q <= owner_mem[victim_q];
		end
		if (cmd.commit_miss) begin
			tag_q[fill_q]    <= page_q;
			tframe_q[fill_q] <= miss_frame;
			if (fault_now) begin
				map_mem[page_q]     <= victim_q;
				owner_mem[victim_q] <= page_q;
			end
		end
		if (cmd.commit_hit || cmd.commit_miss) begin
			physical_address <= {frame_ext[PAFW-1:0], offset_q};
			tlb_hit          <= cmd.commit_hit;
			page_fault       <= fault_commit;
			evicted_valid    <= cmd.commit_miss && evict_now;
			evicted_page     <= (cmd.commit_miss && evict_now) ? NW'(owner_rd_q) : '0;
			hit_total        <= hit_cnt_nx;
			fault_total      <= fault_cnt_nx;
		end
	end

	`ASSERT_CLK_RST(a_tlb_unique, clk, arst_n, $onehot0(match), "several TLB entries match")
	`ASSERT_CLK_RST(a_fill_hits, clk, arst_n, cmd.commit_miss |=> status.tlb_hit, "fill not in TLB")
	`ASSERT_CLK_RST(a_fault_maps, clk, arst_n, fault_commit |=> resident_q[page_q], "fault unmapped")
	`ASSERT_CLK_RST(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped")

endmodule

// ----- sv/tlb_page_table_translator.sv -----
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Logical to physical address translation through a TLB and a page table
// with FIFO frame replacement.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  ----------+-----+-----------------------------------------------------------
//  request   | in  | logical_address
//  response  | out | physical_address, tlb_hit, page_fault, evicted_valid,
//            |     | evicted_page, hit_total, fault_total
//
// One item at a time: a TLB hit goes through accept and lookup, and a miss
// adds a commit step, as the page table and frame owner reads are registered.
// The result is registered at the commit of the item.
// Reset clears all valid bits, pointers and counters at once; no sweep.
// A result waits in the output register; a new item is taken meanwhile and
// holds at commit until that register frees.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
	parameter int TLB_ENTRIES = 16,
	parameter int PAGE_COUNT  = 256,
	parameter int FRAME_TOTAL = 128
) (
	input logic         clk,
	input logic         arst_n,
	tlbpt_req_if.sink   request,
	tlbpt_rsp_if.source response
);

	tlbpt_pkg::tlbpt_cmd_t    cmd;
	tlbpt_pkg::tlbpt_status_t status;

	tlbpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.status   (status),
		.cmd      (cmd)
	);

	tlbpt_datapath #(
		.TLB_ENTRIES (TLB_ENTRIES),
		.PAGE_COUNT  (PAGE_COUNT),
		.FRAME_TOTAL (FRAME_TOTAL)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.logical_address  (request.logical_address),
		.cmd              (cmd),
		.status           (status),
		.out_ready        (response.ready),
		.out_valid        (response.valid),
		.physical_address (response.physical_address),
		.tlb_hit          (response.tlb_hit),
		.page_fault       (response.page_fault),
		.evicted_valid    (response.evicted_valid),
		.evicted_page     (response.evicted_page),
		.hit_total        (response.hit_total),
		.fault_total      (response.fault_total)
	);

endmodule

// ----- tb/tlb_page_table_translator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator_tb
// Sends logical addresses through the request channel and checks every
// translation item against a cycle-free model of the TLB, the page table and
// FIFO frame replacement. The run opens with directed addresses, then sends
// random traffic built from hot pages, resident pages and a page sweep, which
// forces faults and evictions. Both channels idle at random.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_tb;

	localparam int ADDR_W      = tlbpt_pkg::ADDR_W;
	localparam int OFFSET_W    = tlbpt_pkg::OFFSET_W;
	localparam int PAGE_NUM_W  = tlbpt_pkg::PAGE_NUM_W;
	localparam int PA_W        = tlbpt_pkg::PA_W;
	localparam int CNT_W       = tlbpt_pkg::CNT_W;
	localparam int TLB_SLOTS   = 16;
	localparam int PAGE_SLOTS  = 256;
	localparam int FRAME_SLOTS = 128;
	localparam int FRAME_W     = $clog2(FRAME_SLOTS);
	localparam int SLOT_W      = $clog2(TLB_SLOTS);
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 300;
	localparam int HOT_PAGES   = 8;
	localparam int WARM_PAGES  = 40;

	typedef struct packed {
		logic [PA_W-1:0]       physical_address;
		logic                  tlb_hit;
		logic                  page_fault;
		logic                  evicted_valid;
		logic [PAGE_NUM_W-1:0] evicted_page;
		logic [CNT_W-1:0]      hit_total;
		logic [CNT_W-1:0]      fault_total;
	} xlat_result_t;

	class xlat_tracker;
		xlat_result_t          expected_q[$];
		int                    errors;
		bit [PAGE_NUM_W-1:0]   tlb_tag[TLB_SLOTS];
		bit [FRAME_W-1:0]      tlb_frame[TLB_SLOTS];
		bit                    tlb_vld[TLB_SLOTS];
		bit [SLOT_W-1:0]       fill_ptr;
		bit [FRAME_W-1:0]      frame_of_page[PAGE_SLOTS];
		bit                    resident[PAGE_SLOTS];
		bit [PAGE_NUM_W-1:0]   owner[FRAME_SLOTS];
		bit                    owner_vld[FRAME_SLOTS];
		bit [FRAME_W-1:0]      next_victim;
		bit [CNT_W-1:0]        hits;
		bit [CNT_W-1:0]        faults;

		function void note_address(logic [ADDR_W-1:0] addr);
			xlat_result_t        r;
			bit [PAGE_NUM_W-1:0] page;
			bit [OFFSET_W-1:0]   offset;
			bit [PAGE_NUM_W-1:0] prev_owner;
			bit [FRAME_W-1:0]    frame;
			bit                  found;
			int                  i;
			page   = addr[ADDR_W-1:OFFSET_W];
			offset = addr[OFFSET_W-1:0];
			r      = '0;
			frame  = '0;
			found  = 1'b0;
			for (i = 0; i < TLB_SLOTS; i++) begin
				if (!found && tlb_vld[i] && tlb_tag[i] == page) begin
					found = 1'b1;
					frame = tlb_frame[i];
				end
			end
			if (found) begin
				hits++;
				r.tlb_hit = 1'b1;
			end else begin
				if (resident[page]) begin
					frame = frame_of_page[page];
				end else begin
					frame = next_victim;
					next_victim++;
					if (owner_vld[frame]) begin
						prev_owner = owner[frame];
						r.evicted_valid = 1'b1;
						r.evicted_page  = prev_owner;
						resident[prev_owner] = 1'b0;
						for (i = 0; i < TLB_SLOTS; i++) begin
							if (tlb_vld[i] && tlb_tag[i] == prev_owner)
								tlb_vld[i] = 1'b0;
						end
					end
					frame_of_page[page] = frame;
					resident[page]      = 1'b1;
					owner[frame]        = page;
					owner_vld[frame]    = 1'b1;
					r.page_fault        = 1'b1;
					faults++;
				end
				tlb_tag[fill_ptr]   = page;
				tlb_frame[fill_ptr] = frame;
				tlb_vld[fill_ptr]   = 1'b1;
				fill_ptr++;
			end
			r.physical_address = {frame, offset};
			r.hit_total        = hits;
			r.fault_total      = faults;
			expected_q.push_back(r);
		endfunction

		function void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch %s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		function void check_result(xlat_result_t got);
			xlat_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected item: physical_address %0h", got.physical_address);
				return;
			end
			want = expected_q.pop_front();
			check_field("physical_address", CNT_W'(want.physical_address),
				CNT_W'(got.physical_address));
			check_field("tlb_hit", CNT_W'(want.tlb_hit), CNT_W'(got.tlb_hit));
			check_field("page_fault", CNT_W'(want.page_fault), CNT_W'(got.page_fault));
			check_field("evicted_valid", CNT_W'(want.evicted_valid),
				CNT_W'(got.evicted_valid));
			check_field("evicted_page", CNT_W'(want.evicted_page), CNT_W'(got.evicted_page));
			check_field("hit_total", want.hit_total, got.hit_total);
			check_field("fault_total", want.fault_total, got.fault_total);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   send_idle_pct;
	int   recv_idle_pct;

	logic [PAGE_NUM_W-1:0] hot_pages[HOT_PAGES];
	logic [PAGE_NUM_W-1:0] warm_pages[WARM_PAGES];
	logic [PAGE_NUM_W-1:0] sweep_page;

	xlat_tracker tracker = new();

	tlbpt_req_if request_if ();
	tlbpt_rsp_if response_if ();

	tlb_page_table_translator #(
		.TLB_ENTRIES (TLB_SLOTS),
		.PAGE_COUNT  (PAGE_SLOTS),
		.FRAME_TOTAL (FRAME_SLOTS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request_if),
		.response (response_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** tlb_page_table_translator: FAILED **");
			$finish;
		end
	end

	initial begin
		response_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && response_if.valid && response_if.ready)
				tracker.check_result('{response_if.physical_address, response_if.tlb_hit,
					response_if.page_fault, response_if.evicted_valid,
					response_if.evicted_page, response_if.hit_total,
					response_if.fault_total});
			response_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_address(input logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			request_if.valid <= 1'b0;
			@(posedge clk);
		end
		request_if.valid           <= 1'b1;
		request_if.logical_address <= addr;
		@(posedge clk);
		while (!request_if.ready)
			@(posedge clk);
		tracker.note_address(addr);
	endtask

	task automatic wait_for_drain();
		request_if.valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// hot pages mostly hit, warm pages mostly miss the TLB but stay resident,
	// the sweep walks all pages and keeps the FIFO evicting
	function automatic logic [ADDR_W-1:0] pick_address();
		int                    sel;
		logic [PAGE_NUM_W-1:0] page;
		logic [OFFSET_W-1:0]   offset;
		sel    = $urandom_range(99);
		offset = OFFSET_W'($urandom_range(255));
		if (sel < 40) begin
			page = hot_pages[$urandom_range(HOT_PAGES - 1)];
		end else if (sel < 65) begin
			page = warm_pages[$urandom_range(WARM_PAGES - 1)];
		end else if (sel < 90) begin
			page = sweep_page;
			sweep_page++;
		end else begin
			page = PAGE_NUM_W'($urandom_range(255));
		end
		return {page, offset};
	endfunction

	task automatic run_phase(input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (PHASE_ITEMS)
			send_address(pick_address());
	endtask

	initial begin
		int i;
		arst_n                     <= 1'b0;
		request_if.valid           <= 1'b0;
		request_if.logical_address <= '0;
		send_idle_pct = 35;
		recv_idle_pct = 59;
		for (i = 0; i < HOT_PAGES; i++)
			hot_pages[i] = PAGE_NUM_W'($urandom_range(255));
		for (i = 0; i < WARM_PAGES; i++)
			warm_pages[i] = PAGE_NUM_W'($urandom_range(255));
		sweep_page = PAGE_NUM_W'($urandom_range(255));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of page and offset, then TLB hits on the same pages
		send_address(16'h0000);
		send_address(16'h00FF);
		send_address(16'hFFFF);
		send_address(16'hFF00);
		send_address(16'h5AA5);
		send_address(16'hA55A);
		// wrap the fill pointer so the early pages leave the TLB
		for (i = 1; i <= 16; i++)
			send_address({i[PAGE_NUM_W-1:0], 8'($urandom_range(255))});
		// TLB misses on pages that are still resident
		send_address(16'h0033);
		send_address(16'hFF80);

		run_phase(35, 59);
		wait_for_drain();
		run_phase(59, 35);
		wait_for_drain();
		run_phase(0, 0);
		wait_for_drain();
		repeat (20) @(posedge clk);

		if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
			$display("** tlb_page_table_translator: PASSED **");
		end else begin
			$display("errors %0d, items still expected %0d", tracker.errors,
				tracker.expected_q.size());
			$display("** tlb_page_table_translator: FAILED **");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/tlbpt_pkg.sv
sv/tlbpt_channels.sv
sv/tlbpt_ctrl.sv
sv/tlbpt_datapath.sv
sv/tlb_page_table_translator.sv
tb/tlb_page_table_translator_tb.sv
